@@ sv/ble_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ble_pkg
// Shared constants and types of the backspace line-edit stack.
// ----------------------------------------------------------------------------
package ble_pkg;

  localparam int unsigned BLE_DEPTH = 64;

  localparam logic [7:0] KeyNewline     = 8'd10;
  localparam logic [7:0] KeyNul         = 8'd0;
  localparam logic [7:0] BackspaceReset = 8'd66;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StEmit,
    StEmpty
  } ctrl_state_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic rd_en;
    logic ptr_clr;
    logic ptr_inc;
    logic load_char;
    logic load_empty;
    logic flush_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_flush;
    logic is_bs;
    logic cnt_zero;
    logic ptr_last;
    logic slot_free;
  } dp_status_t;

endpackage
`default_nettype wire

@@ sv/ble_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ble_if
// Key and result channel interfaces, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ble_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key;
  logic       end_of_line;

  modport source (output valid, output key, output end_of_line, input ready);
  modport sink   (input valid, input key, input end_of_line, output ready);
endinterface

interface ble_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  logic       empty_res;
  logic       overflow;

  modport source (output valid, output out_char, output last, output empty_res,
                  output overflow, input ready);
  modport sink   (input valid, input out_char, input last, input empty_res,
                  input overflow, output ready);
endinterface
`default_nettype wire

@@ sv/ble_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ble_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ble_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/ble_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ble_ctrl
// Controller: key acceptance and flush sequencing.
// ----------------------------------------------------------------------------
module ble_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire ble_pkg::dp_status_t sts_i,
  output      ble_pkg::ctrl_cmd_t  cmd_o
);
  import ble_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          priority if (sts_i.is_flush) begin
            if (sts_i.cnt_zero) begin
              state_d = StEmpty;
            end else begin
              cmd_o.ptr_clr = 1'b1;
              state_d       = StRead;
            end
          end else if (sts_i.is_bs) begin
            cmd_o.pop = 1'b1;
          end else begin
            cmd_o.push = 1'b1;
          end
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StEmit;
      end
      StEmit: begin
        if (sts_i.slot_free) begin
          cmd_o.load_char = 1'b1;
          if (sts_i.ptr_last) begin
            cmd_o.flush_done = 1'b1;
            state_d          = StIdle;
          end else begin
            cmd_o.ptr_inc = 1'b1;
            state_d       = StRead;
          end
        end
      end
      StEmpty: begin
        if (sts_i.slot_free) begin
          cmd_o.load_empty = 1'b1;
          cmd_o.flush_done = 1'b1;
          state_d          = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/ble_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ble_dp
// Datapath: key decode, stack count, overflow flag, char store, result register.
// ----------------------------------------------------------------------------
module ble_dp #(
  parameter int unsigned DEPTH = ble_pkg::BLE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire logic [7:0]         key_i,
  input  wire logic               end_of_line_i,
  input  wire logic               out_ready_i,
  output      logic               out_valid_o,
  output      logic [7:0]         out_char_o,
  output      logic               last_o,
  output      logic               empty_res_o,
  output      logic               overflow_o,
  input  wire ble_pkg::ctrl_cmd_t cmd_i,
  output      ble_pkg::dp_status_t sts_o
);
  import ble_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  logic [7:0]    bs_code_q;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          out_valid_q;
  logic [7:0]    out_char_q;
  logic          last_q;
  logic          empty_q;
  logic          ovf_out_q;
  logic [7:0]    rdata;
  logic          full;
  logic          ram_we;

  assign full   = (count_q >= DepthC);
  assign ram_we = cmd_i.push && !full;

  ble_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (key_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    ptr_d   = ptr_q;
    priority if (cmd_i.flush_done) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (cmd_i.pop) begin
      if (count_q != '0) begin
        count_d = count_q - CW'(1);
      end
    end else if (cmd_i.push) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
    end
    priority if (cmd_i.ptr_clr) begin
      ptr_d = '0;
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_code_q   <= BackspaceReset;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bs_code_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      ovf_q   <= ovf_d;
      ptr_q   <= ptr_d;
      if (cmd_i.load_char || cmd_i.load_empty) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_char) begin
      out_char_q <= rdata;
      last_q     <= sts_o.ptr_last;
      empty_q    <= 1'b0;
      ovf_out_q  <= ovf_q;
    end else if (cmd_i.load_empty) begin
      out_char_q <= '0;
      last_q     <= 1'b1;
      empty_q    <= 1'b1;
      ovf_out_q  <= ovf_q;
    end
  end

  assign sts_o.is_flush  = end_of_line_i || (key_i == KeyNewline) || (key_i == KeyNul);
  assign sts_o.is_bs     = (key_i == bs_code_q);
  assign sts_o.cnt_zero  = (count_q == '0);
  assign sts_o.ptr_last  = (CW'(ptr_q) == (count_q - CW'(1)));
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = last_q;
  assign empty_res_o = empty_q;
  assign overflow_o  = ovf_out_q;

endmodule
`default_nettype wire

@@ sv/backspace_line_edit_stack_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// backspace_line_edit_stack_top
// Stack-based line editor with backspace, flush on newline, NUL or end_of_line.
// Edit keys: one per cycle, no result; keys wait until a flush ends.
// Flush of N chars: StRead reads each char (char store read is registered),
//   StEmit loads it once the result slot frees. Empty flush: via StEmpty.
// Reset clears count, overflow flag and result valid; backspace code -> 66.
// ----------------------------------------------------------------------------
module backspace_line_edit_stack_top #(
  parameter int unsigned DEPTH = ble_pkg::BLE_DEPTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  ble_key_if.sink     key_i,
  ble_res_if.source   res_o
);
  import ble_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  ble_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (key_i.valid),
    .in_ready_o (key_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ble_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .key_i         (key_i.key),
    .end_of_line_i (key_i.end_of_line),
    .out_ready_i   (res_o.ready),
    .out_valid_o   (res_o.valid),
    .out_char_o    (res_o.out_char),
    .last_o        (res_o.last),
    .empty_res_o   (res_o.empty_res),
    .overflow_o    (res_o.overflow),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
`default_nettype wire

@@ test/backspace_line_edit_stack_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backspace_line_edit_stack_top_test
// Self-checking bench for the line-edit stack. A short table of edit and flush
// keys comes first, then random lines with backspaces, overlong lines and junk
// keys under several backspace codes. Both channels idle at random. Flush
// results are checked against a behavioral line buffer or a fixed table row.
// ----------------------------------------------------------------------------
module backspace_line_edit_stack_top_test;
  import ble_pkg::*;

  localparam int RandItems = 430;
  localparam int NumRows   = 26;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty;
    logic       ovf;
  } line_res_t;

  typedef enum logic [0:0] {RowKey, RowCfg} row_kind_e;
  typedef enum logic [1:0] {ChkModel, ChkNone, ChkOne} row_check_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] key;
    logic       eol;
    row_check_e chk;
    line_res_t  res;
  } row_t;

  // key rows: key, end_of_line, how to check; cfg rows: key holds the code
  row_t dir_rows [NumRows] = '{
    '{RowKey, 8'h55,          1'b1, ChkOne,   '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{RowKey, KeyNewline,     1'b0, ChkOne,   '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{RowKey, KeyNul,         1'b0, ChkOne,   '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{RowKey, BackspaceReset, 1'b0, ChkNone,  '0},
    '{RowKey, 8'h41,          1'b0, ChkNone,  '0},
    '{RowKey, 8'hFF,          1'b0, ChkNone,  '0},
    '{RowKey, 8'h01,          1'b0, ChkNone,  '0},
    '{RowKey, BackspaceReset, 1'b0, ChkNone,  '0},
    '{RowKey, 8'hAA,          1'b1, ChkModel, '0},
    '{RowKey, 8'h43,          1'b0, ChkNone,  '0},
    '{RowKey, KeyNewline,     1'b0, ChkOne,   '{8'h43, 1'b1, 1'b0, 1'b0}},
    '{RowCfg, KeyNewline,     1'b0, ChkNone,  '0},
    '{RowKey, 8'h05,          1'b0, ChkNone,  '0},
    '{RowKey, KeyNewline,     1'b0, ChkOne,   '{8'h05, 1'b1, 1'b0, 1'b0}},
    '{RowKey, BackspaceReset, 1'b0, ChkNone,  '0},
    '{RowKey, 8'h80,          1'b0, ChkNone,  '0},
    '{RowKey, KeyNul,         1'b0, ChkModel, '0},
    '{RowCfg, 8'h00,          1'b0, ChkNone,  '0},
    '{RowKey, 8'h07,          1'b0, ChkNone,  '0},
    '{RowKey, KeyNul,         1'b0, ChkOne,   '{8'h07, 1'b1, 1'b0, 1'b0}},
    '{RowCfg, 8'hFF,          1'b0, ChkNone,  '0},
    '{RowKey, 8'hFE,          1'b0, ChkNone,  '0},
    '{RowKey, 8'hFF,          1'b0, ChkNone,  '0},
    '{RowKey, 8'h7F,          1'b0, ChkNone,  '0},
    '{RowKey, 8'h00,          1'b1, ChkModel, '0},
    '{RowCfg, BackspaceReset, 1'b0, ChkNone,  '0}
  };

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  ble_key_if key_if ();
  ble_res_if res_if ();

  backspace_line_edit_stack_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .key_i       (key_if),
    .res_o       (res_if)
  );

  // line buffer shadow
  logic [7:0]  line_chars [BLE_DEPTH];
  int unsigned line_len;
  logic        line_ovf;
  logic [7:0]  bs_code;

  line_res_t   staged_q [$];
  line_res_t   expected_q [$];
  int          mismatch_cnt;
  bit          key_quiet;
  bit          res_quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("ERROR: timeout");
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 50) $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic void edit_line(input logic [7:0] k, input logic e);
    line_res_t r;
    staged_q.delete();
    if (e || k == KeyNewline || k == KeyNul) begin
      if (line_len == 0) begin
        r = '{8'h00, 1'b1, 1'b1, line_ovf};
        staged_q.push_back(r);
      end else begin
        for (int i = 0; i < line_len; i++) begin
          r = '{line_chars[i], (i == line_len - 1), 1'b0, line_ovf};
          staged_q.push_back(r);
        end
      end
      line_len = 0;
      line_ovf = 1'b0;
    end else if (k == bs_code) begin
      if (line_len > 0) line_len--;
    end else if (line_len >= BLE_DEPTH) begin
      line_ovf = 1'b1;
    end else begin
      line_chars[line_len] = k;
      line_len++;
    end
  endfunction

  task automatic send_key(input logic [7:0] k, input logic e, input bit use_shadow);
    int gap;
    gap = key_quiet ? 0 : $urandom_range(14, 0);
    if (gap > 0) begin
      key_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_if.valid       <= 1'b1;
    key_if.key         <= k;
    key_if.end_of_line <= e;
    do @(posedge clk); while (key_if.ready !== 1'b1);
    edit_line(k, e);
    if (use_shadow) begin
      foreach (staged_q[i]) expected_q.push_back(staged_q[i]);
    end
  endtask

  task automatic set_backspace(input logic [7:0] code);
    key_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we  <= 1'b0;
    bs_code = code;
  endtask

  // result sink with random stalls
  initial begin
    line_res_t want;
    int        gap;
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = res_quiet ? 0 : $urandom_range(14, 0);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (res_if.valid !== 1'b1);
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, out_char %02h", res_if.out_char));
      end else begin
        want = expected_q.pop_front();
        if (!want.empty && res_if.out_char !== want.ch)
          report_mismatch($sformatf("out_char %02h, want %02h", res_if.out_char, want.ch));
        if (res_if.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", res_if.last, want.last));
        if (res_if.empty_res !== want.empty)
          report_mismatch($sformatf("empty_res %b, want %b", res_if.empty_res, want.empty));
        if (res_if.overflow !== want.ovf)
          report_mismatch($sformatf("overflow %b, want %b", res_if.overflow, want.ovf));
      end
    end
  end

  initial begin
    int         rand_sent;
    int         phase;
    int         phase_end;
    int         line_cnt;
    int         len;
    bit         bs_ok;
    logic [7:0] c;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= 8'h00;
    key_if.valid       <= 1'b0;
    key_if.key         <= 8'h00;
    key_if.end_of_line <= 1'b0;
    line_len     = 0;
    line_ovf     = 1'b0;
    bs_code      = BackspaceReset;
    mismatch_cnt = 0;
    key_quiet    = 1'b0;
    res_quiet    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowCfg) begin
        set_backspace(dir_rows[i].key);
      end else begin
        send_key(dir_rows[i].key, dir_rows[i].eol, dir_rows[i].chk == ChkModel);
        if (dir_rows[i].chk == ChkOne) expected_q.push_back(dir_rows[i].res);
      end
    end

    rand_sent = 0;
    phase     = 0;
    line_cnt  = 0;
    while (rand_sent < RandItems) begin
      case ($urandom_range(5, 0))
        0:       set_backspace(8'h00);
        1:       set_backspace(8'hFF);
        2:       set_backspace(BackspaceReset);
        3:       set_backspace(KeyNewline);
        default: set_backspace(8'($urandom_range(255, 0)));
      endcase
      key_quiet = ($urandom_range(3, 0) == 0);
      res_quiet = ($urandom_range(3, 0) == 0);
      phase_end = rand_sent + $urandom_range(60, 35);
      while (rand_sent < phase_end && rand_sent < RandItems) begin
        if ($urandom_range(9, 0) == 0) begin
          // junk keys, any value
          repeat ($urandom_range(5, 1)) begin
            send_key(8'($urandom_range(255, 0)), ($urandom_range(3, 0) == 0), 1'b1);
            rand_sent++;
          end
        end else begin
          if (phase == 0 && line_cnt == 0) len = 72;
          else if ($urandom_range(11, 0) == 0) len = $urandom_range(72, 62);
          else len = $urandom_range(12, 0);
          bs_ok = (len <= 12);
          repeat (len) begin
            if (bs_ok && $urandom_range(6, 0) == 0) begin
              c = bs_code;
            end else begin
              do c = 8'($urandom_range(255, 1)); while (c == KeyNewline || c == bs_code);
            end
            send_key(c, 1'b0, 1'b1);
            rand_sent++;
          end
          case ($urandom_range(2, 0))
            0:       send_key(8'($urandom_range(255, 0)), 1'b1, 1'b1);
            1:       send_key(KeyNewline, 1'b0, 1'b1);
            default: send_key(KeyNul, 1'b0, 1'b1);
          endcase
          rand_sent++;
          line_cnt++;
        end
      end
      phase++;
    end

    key_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
